// File: hdl/sacpu_pkg.sv
// Shared types and constants for the stack accumulator execute block.
// Used by sacpu_muldiv and stack_accumulator_cpu_execute; no dependencies.
`default_nettype none
package sacpu_pkg;

  typedef enum logic [4:0] {
    OP_LDI = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_DUP = 5'd3, OP_SWAP = 5'd4,
    OP_TOP = 5'd5, OP_OVER = 5'd6, OP_INC = 5'd7, OP_DEC = 5'd8, OP_ADD = 5'd9,
    OP_SUB = 5'd10, OP_MUL = 5'd11, OP_DIV = 5'd12, OP_EQ = 5'd13, OP_NEQ = 5'd14,
    OP_LT = 5'd15, OP_LTE = 5'd16, OP_GT = 5'd17, OP_GTE = 5'd18, OP_JMP = 5'd19,
    OP_NOT = 5'd20, OP_JZ = 5'd21, OP_JNZ = 5'd22, OP_CALL = 5'd23, OP_RET = 5'd24
  } opcode_t;

  typedef enum logic [2:0] {
    ERR_OK = 3'd0, ERR_UNDERFLOW = 3'd1, ERR_OVERFLOW = 3'd2,
    ERR_CALL_OVERFLOW = 3'd3, ERR_CALL_UNDERFLOW = 3'd4, ERR_DIV_ZERO = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_SWAP2, ST_WAIT, ST_RESULT
  } state_t;

  typedef struct packed {
    logic [4:0]  req_type;
    logic signed [31:0] immediate_value;
    logic [15:0] target_address;
  } req_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic signed [31:0] acc_value;
    logic [2:0]  error_code;
    logic        program_done;
  } rsp_t;

  // Command and status between the sequencer and the multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] result;
  } md_stat_t;

endpackage
`default_nettype wire

// File: hdl/sacpu_muldiv.sv
// Iterative 32-bit multiply (shift-add) and signed truncating divide (restoring).
// One bit per cycle, 32 steps plus a sign fix-up step. Uses sacpu_pkg.
`default_nettype none
module sacpu_muldiv import sacpu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire md_cmd_t     cmd,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output md_stat_t         stat
);

  typedef enum logic [1:0] {MD_IDLE, MD_RUN, MD_FIX} md_state_t;

  md_state_t   mstate;
  logic [5:0]  count;
  logic        div_mode;
  logic        negate;
  logic [31:0] acc;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [32:0] rem;
  logic [32:0] rem_shift;
  logic [32:0] rem_sub;

  assign rem_shift = {rem[31:0], opa[31]};
  assign rem_sub   = rem_shift - {1'b0, opb};

  // Sequencer and datapath for both operations.
  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= MD_IDLE;
      count  <= '0;
    end else begin
      unique case (mstate)
        MD_IDLE: begin
          if (cmd.start) begin
            mstate   <= MD_RUN;
            count    <= 6'd0;
            div_mode <= cmd.is_div;
            rem      <= '0;
            acc      <= '0;
            if (cmd.is_div) begin
              opa    <= a[31] ? (32'd0 - a) : a;
              opb    <= b[31] ? (32'd0 - b) : b;
              negate <= a[31] ^ b[31];
            end else begin
              opa    <= a;
              opb    <= b;
              negate <= 1'b0;
            end
          end
        end
        MD_RUN: begin
          if (div_mode) begin
            // Restoring division: one quotient bit per step.
            opa <= {opa[30:0], 1'b0};
            if (!rem_sub[32]) begin
              rem <= rem_sub;
              acc <= {acc[30:0], 1'b1};
            end else begin
              rem <= rem_shift;
              acc <= {acc[30:0], 1'b0};
            end
          end else begin
            // Shift-add multiply, low 32 bits only.
            if (opb[0]) acc <= acc + opa;
            opa <= {opa[30:0], 1'b0};
            opb <= {1'b0, opb[31:1]};
          end
          count <= count + 6'd1;
          if (count == 6'd31) mstate <= MD_FIX;
        end
        MD_FIX: begin
          if (negate) acc <= 32'd0 - acc;
          mstate <= MD_IDLE;
        end
        default: mstate <= MD_IDLE;
      endcase
    end
  end

  always_comb begin
    stat.busy   = (mstate != MD_IDLE);
    stat.done   = (mstate == MD_FIX);
    stat.result = negate ? (32'd0 - acc) : acc;
  end

  // The step counter only moves while running.
  assert property (@(posedge clk) disable iff (rst)
    (mstate == MD_IDLE) |=> ($stable(count) || $past(cmd.start)))
    else $error("muldiv counter moved while idle");
  assert property (@(posedge clk) disable iff (rst)
    (mstate == MD_FIX) |=> (mstate == MD_IDLE))
    else $error("muldiv fix-up did not finish");
  assert property (@(posedge clk) disable iff (rst)
    (mstate == MD_RUN && count != 6'd31) |=> (mstate == MD_RUN))
    else $error("muldiv left run early");

endmodule
`default_nettype wire

// File: hdl/stack_accumulator_cpu_execute.sv
// Executes one instruction per item. A result is offered after the states ST_READ (read
// stack memory) and ST_EXEC for most ops, with ST_SWAP2 added for swap and ST_WAIT for mul
// and div, which lasts while the 32-step multiply/divide unit and its sign fix-up run.
// One item is in flight at a time, and the next is accepted only after the result has left.
// Synchronous reset clears accumulator, pc, stack depths and program length; the stack
// memories hold no reset value and need none, since values read beyond depth are never used.
`default_nettype none
module stack_accumulator_cpu_execute import sacpu_pkg::*; #(
  parameter int DATA_STACK_DEPTH = 256,
  parameter int CALL_STACK_DEPTH = 64,
  parameter int PC_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output rsp_t             out_data
);

  localparam int DAW = (DATA_STACK_DEPTH > 1) ? $clog2(DATA_STACK_DEPTH) : 1;
  localparam int DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int CAW = (CALL_STACK_DEPTH > 1) ? $clog2(CALL_STACK_DEPTH) : 1;
  localparam int CDW = $clog2(CALL_STACK_DEPTH + 1);

  state_t state, state_next;

  logic [15:0]         program_length;
  logic [31:0]         accumulator;
  logic [PC_WIDTH-1:0] pc;
  logic [DDW-1:0]      data_depth;
  logic [CDW-1:0]      call_depth;
  req_t                req;

  // Stack memories, one write and registered reads.
  logic [31:0]         dmem [DATA_STACK_DEPTH];
  logic [PC_WIDTH-1:0] cmem [CALL_STACK_DEPTH];
  logic [31:0]         rd_top;
  logic [31:0]         rd_sec;
  logic [PC_WIDTH-1:0] rd_ret;

  logic [DDW-1:0] top_idx;
  logic [DDW-1:0] sec_idx;
  logic [CDW-1:0] ret_idx;
  assign top_idx = data_depth - DDW'(1);
  assign sec_idx = data_depth - DDW'(2);
  assign ret_idx = call_depth - CDW'(1);

  logic           dwe;
  logic [DDW-1:0] dwa;
  logic [31:0]    dwd;
  logic           cwe;

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_top <= dmem[top_idx[DAW-1:0]];
      rd_sec <= dmem[sec_idx[DAW-1:0]];
      rd_ret <= cmem[ret_idx[CAW-1:0]];
    end
    if (dwe) dmem[dwa[DAW-1:0]] <= dwd;
    if (cwe) cmem[call_depth[CAW-1:0]] <= pc;
  end

  md_cmd_t  md_cmd;
  md_stat_t md_stat;
  sacpu_muldiv u_md (
    .clk (clk), .rst (rst), .cmd (md_cmd),
    .a (accumulator), .b (rd_top), .stat (md_stat)
  );

  // Decode of the held item.
  opcode_t        op;
  logic [PC_WIDTH-1:0] target;
  logic [PC_WIDTH-1:0] pc_inc;
  logic           need1, need2, push_op;
  logic [2:0]     err;
  assign op     = opcode_t'(req.req_type);
  assign target = PC_WIDTH'(req.target_address);
  assign pc_inc = pc + PC_WIDTH'(1);

  always_comb begin
    need1 = 1'b0;
    need2 = 1'b0;
    push_op = 1'b0;
    case (op) inside
      OP_POP, OP_DUP, OP_TOP, [OP_ADD:OP_GTE]: need1 = 1'b1;
      OP_SWAP, OP_OVER: need2 = 1'b1;
      default: ;
    endcase
    if (op == OP_PUSH || op == OP_DUP) push_op = 1'b1;
    err = ERR_OK;
    if (need1 && data_depth < DDW'(1)) err = ERR_UNDERFLOW;
    else if (need2 && data_depth < DDW'(2)) err = ERR_UNDERFLOW;
    else if (push_op && data_depth >= DDW'(DATA_STACK_DEPTH)) err = ERR_OVERFLOW;
    else if (op == OP_DIV && rd_top == 32'd0) err = ERR_DIV_ZERO;
    else if (op == OP_CALL && call_depth >= CDW'(CALL_STACK_DEPTH))
      err = ERR_CALL_OVERFLOW;
    else if (op == OP_RET && call_depth == '0) err = ERR_CALL_UNDERFLOW;
  end

  // Shared ALU result for the operations other than multiply and divide.
  logic [31:0] alu;
  logic signed [31:0] sa, sb;
  assign sa = accumulator;
  assign sb = rd_top;
  always_comb begin
    case (op)
      OP_LDI:  alu = req.immediate_value;
      OP_POP, OP_TOP: alu = rd_top;
      OP_OVER: alu = rd_sec;
      OP_INC:  alu = accumulator + 32'd1;
      OP_DEC:  alu = accumulator - 32'd1;
      OP_ADD:  alu = accumulator + rd_top;
      OP_SUB:  alu = accumulator - rd_top;
      OP_EQ:   alu = {31'd0, accumulator == rd_top};
      OP_NEQ:  alu = {31'd0, accumulator != rd_top};
      OP_LT:   alu = {31'd0, sa < sb};
      OP_LTE:  alu = {31'd0, sa <= sb};
      OP_GT:   alu = {31'd0, sa > sb};
      OP_GTE:  alu = {31'd0, sa >= sb};
      OP_NOT:  alu = {31'd0, accumulator == 32'd0};
      default: alu = accumulator;
    endcase
  end

  logic err_q;
  logic [2:0] err_code;

  // Next state and memory write control.
  always_comb begin
    state_next = state;
    dwe = 1'b0;
    dwa = data_depth;
    dwd = accumulator;
    cwe = 1'b0;
    md_cmd = '0;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC: begin
        if (err != ERR_OK) state_next = ST_RESULT;
        else if (op == OP_MUL || op == OP_DIV) begin
          md_cmd.start = 1'b1;
          md_cmd.is_div = (op == OP_DIV);
          state_next = ST_WAIT;
        end else begin
          state_next = (op == OP_SWAP) ? ST_SWAP2 : ST_RESULT;
          if (op == OP_PUSH) dwe = 1'b1;
          if (op == OP_DUP) begin
            dwe = 1'b1;
            dwd = rd_top;
          end
          if (op == OP_SWAP) begin
            dwe = 1'b1;
            dwa = top_idx;
            dwd = rd_sec;
          end
          if (op == OP_CALL) cwe = 1'b1;
        end
      end
      ST_SWAP2: begin
        dwe = 1'b1;
        dwa = sec_idx;
        dwd = rd_top;
        state_next = ST_RESULT;
      end
      ST_WAIT:  if (md_stat.done) state_next = ST_RESULT;
      ST_RESULT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Architectural state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      accumulator <= '0;
      pc <= '0;
      data_depth <= '0;
      call_depth <= '0;
      err_code <= ERR_OK;
      err_q <= 1'b0;
    end else begin
      if (cfg_we) program_length <= cfg_wdata;
      if (state == ST_IDLE && in_valid) req <= in_data;
      if (state == ST_WAIT && md_stat.done) accumulator <= md_stat.result;
      if (state == ST_EXEC) begin
        err_code <= err;
        err_q <= (err != ERR_OK);
        if (err == ERR_OK) begin
          if (op != OP_MUL && op != OP_DIV) accumulator <= alu;
          if (push_op) data_depth <= data_depth + DDW'(1);
          if (need1 && op != OP_DUP && op != OP_TOP)
            data_depth <= data_depth - DDW'(1);
          unique case (op)
            OP_JMP:  pc <= target;
            OP_JZ:   pc <= (accumulator == 32'd0) ? target : pc_inc;
            OP_JNZ:  pc <= (accumulator != 32'd0) ? target : pc_inc;
            OP_CALL: begin
              pc <= target;
              call_depth <= call_depth + CDW'(1);
            end
            OP_RET: begin
              pc <= rd_ret + PC_WIDTH'(1);
              call_depth <= call_depth - CDW'(1);
            end
            default: pc <= pc_inc;
          endcase
        end
      end
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_RESULT);
  always_comb begin
    out_data.next_pc = 16'(pc);
    out_data.acc_value = accumulator;
    out_data.error_code = err_code;
    out_data.program_done = (32'(pc) >= 32'(program_length));
  end

  // An error leaves the stack depth and the pc untouched.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && err != ERR_OK) |=> $stable(data_depth) && $stable(pc))
    else $error("error changed state");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> md_stat.busy)
    else $error("waiting with idle muldiv");
  assert property (@(posedge clk) disable iff (rst)
    (data_depth <= DDW'(DATA_STACK_DEPTH)) && (call_depth <= CDW'(CALL_STACK_DEPTH)))
    else $error("stack depth beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (err_q == (err_code != ERR_OK)))
    else $error("error flag mismatch");

endmodule
`default_nettype wire

// File: verif/stack_accumulator_cpu_execute_test.sv
// Self-checking test of the stack accumulator execute block.
// Uses sacpu_pkg types; predicts every instruction result and compares it in order.
`default_nettype none
module stack_accumulator_cpu_execute_test;
  import sacpu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DSTACK = 256;
  localparam int CSTACK = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  stack_accumulator_cpu_execute uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted machine state.
  logic [31:0] m_acc;
  logic [15:0] m_pc;
  int          m_depth;
  logic [31:0] m_data [DSTACK];
  int          m_cdepth;
  logic [15:0] m_ret [CSTACK];
  logic [15:0] m_len;

  rsp_t expected_rsps[$];
  int   failures = 0;
  bit   idle_on = 1'b1;
  bit   long_hold_req = 1'b0;
  int   hold_cycles = 0;
  int   quiet_cycles = 0;

  function automatic logic [31:0] trunc_quot(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Execute one instruction on the predicted state and queue its result.
  task automatic execute_predict(req_t r);
    logic [15:0] nxt;
    err_t        err;
    logic [31:0] t, a;
    rsp_t        rs;
    nxt = m_pc + 16'd1;
    err = ERR_OK;
    a = m_acc;
    case (r.req_type)
      OP_LDI: m_acc = r.immediate_value;
      OP_PUSH: begin
        if (m_depth >= DSTACK) err = ERR_OVERFLOW;
        else begin m_data[m_depth] = m_acc; m_depth++; end
      end
      OP_POP: begin
        if (m_depth < 1) err = ERR_UNDERFLOW;
        else begin m_depth--; m_acc = m_data[m_depth]; end
      end
      OP_DUP: begin
        if (m_depth < 1) err = ERR_UNDERFLOW;
        else if (m_depth >= DSTACK) err = ERR_OVERFLOW;
        else begin m_data[m_depth] = m_data[m_depth-1]; m_depth++; end
      end
      OP_SWAP: begin
        if (m_depth < 2) err = ERR_UNDERFLOW;
        else begin
          t = m_data[m_depth-1];
          m_data[m_depth-1] = m_data[m_depth-2];
          m_data[m_depth-2] = t;
        end
      end
      OP_TOP: begin
        if (m_depth < 1) err = ERR_UNDERFLOW;
        else m_acc = m_data[m_depth-1];
      end
      OP_OVER: begin
        if (m_depth < 2) err = ERR_UNDERFLOW;
        else m_acc = m_data[m_depth-2];
      end
      OP_INC: m_acc = m_acc + 1;
      OP_DEC: m_acc = m_acc - 1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NEQ, OP_LT, OP_LTE, OP_GT, OP_GTE: begin
        if (m_depth < 1) err = ERR_UNDERFLOW;
        else begin
          t = m_data[m_depth-1];
          if (r.req_type == OP_DIV && t == 0) err = ERR_DIV_ZERO;
          else begin
            m_depth--;
            case (r.req_type)
              OP_ADD: m_acc = a + t;
              OP_SUB: m_acc = a - t;
              OP_MUL: m_acc = a * t;
              OP_DIV: m_acc = trunc_quot(a, t);
              OP_EQ:  m_acc = {31'd0, a == t};
              OP_NEQ: m_acc = {31'd0, a != t};
              OP_LT:  m_acc = {31'd0, $signed(a) < $signed(t)};
              OP_LTE: m_acc = {31'd0, $signed(a) <= $signed(t)};
              OP_GT:  m_acc = {31'd0, $signed(a) > $signed(t)};
              default: m_acc = {31'd0, $signed(a) >= $signed(t)};
            endcase
          end
        end
      end
      OP_JMP: nxt = r.target_address;
      OP_NOT: m_acc = {31'd0, m_acc == 0};
      OP_JZ:  if (m_acc == 0) nxt = r.target_address;
      OP_JNZ: if (m_acc != 0) nxt = r.target_address;
      OP_CALL: begin
        if (m_cdepth >= CSTACK) err = ERR_CALL_OVERFLOW;
        else begin m_ret[m_cdepth] = m_pc; m_cdepth++; nxt = r.target_address; end
      end
      OP_RET: begin
        if (m_cdepth < 1) err = ERR_CALL_UNDERFLOW;
        else begin m_cdepth--; nxt = m_ret[m_cdepth] + 16'd1; end
      end
      default: ;
    endcase
    if (err == ERR_OK) m_pc = nxt;
    rs.next_pc = m_pc;
    rs.acc_value = m_acc;
    rs.error_code = err;
    rs.program_done = (m_pc >= m_len);
    expected_rsps.push_back(rs);
  endtask

  // Send one item; predict it at the edge where it is accepted. Valid stays high
  // after acceptance until the next call or stop_sending drives it again.
  task automatic send_item(logic [4:0] op, logic [31:0] imm, logic [15:0] tgt);
    req_t r;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.req_type = op;
    r.immediate_value = imm;
    r.target_address = tgt;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    execute_predict(r);
  endtask

  // Drop valid after the last item of a sequence.
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Wait for all results, let the block settle, then write the length register.
  task automatic set_length(logic [15:0] len);
    stop_sending();
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_len = len;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Result checker: compares each accepted item with the oldest prediction.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result item pc=%0d", out_data.next_pc);
        failures++;
      end else begin
        e = expected_rsps.pop_front();
        if (out_data.next_pc !== e.next_pc) begin
          $error("next_pc exp %0d got %0d", e.next_pc, out_data.next_pc); failures++;
        end
        if (out_data.acc_value !== e.acc_value) begin
          $error("acc_value exp %0d got %0d", e.acc_value, out_data.acc_value); failures++;
        end
        if (out_data.error_code !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, out_data.error_code); failures++;
        end
        if (out_data.program_done !== e.program_done) begin
          $error("program_done exp %0d got %0d", e.program_done, out_data.program_done);
          failures++;
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts, or a long hold when requested.
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_stall <= 1'b1;
      hold_cycles <= LONG_HOLD;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      hold_cycles <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("stack_accumulator_cpu_execute_test NOT OK");
      $finish;
    end
  end

  // Directed extremes, errors, a subset of the opcodes and the special cases.
  task automatic test_directed();
    send_item(OP_POP, 0, 0);
    send_item(OP_SWAP, 0, 0);
    send_item(OP_RET, 0, 0);
    send_item(OP_LDI, 32'h8000_0000, 0);
    send_item(OP_PUSH, 0, 0);
    send_item(OP_DIV, 0, 0);
    send_item(OP_LDI, 0, 0);
    send_item(OP_PUSH, 0, 0);
    send_item(OP_DIV, 0, 0);
    send_item(OP_LDI, 32'hffff_ffff, 0);
    send_item(OP_PUSH, 0, 0);
    send_item(OP_LDI, 32'h8000_0000, 0);
    send_item(OP_DIV, 0, 0);
    send_item(OP_LDI, 32'h7fff_ffff, 16'hffff);
    send_item(OP_DUP, 0, 0);
    send_item(OP_OVER, 0, 0);
    send_item(OP_MUL, 0, 0);
    send_item(OP_JZ, 0, 16'hffff);
    send_item(OP_JNZ, 0, 16'hffff);
    send_item(OP_INC, 0, 0);
    send_item(OP_CALL, 0, 16'h1234);
    send_item(OP_RET, 0, 0);
    send_item(OP_NOT, 0, 0);
    send_item(5'd31, 32'hffff_ffff, 16'hffff);
    send_item(5'd25, 0, 0);
  endtask

  // Fill both stacks past their tops to reach the overflow errors, then drain them past empty.
  task automatic test_overflow();
    for (int i = 0; i < DSTACK + 2; i++) send_item(OP_PUSH, 0, 0);
    send_item(OP_DUP, 0, 0);
    for (int i = 0; i < CSTACK + 2; i++) send_item(OP_CALL, 0, $urandom);
    for (int i = 0; i < CSTACK + 2; i++) send_item(OP_RET, 0, 0);
    for (int i = 0; i < DSTACK + 2; i++) send_item(OP_POP, 0, 0);
  endtask

  // Random programs: pushes, loads and arithmetic weighted up, all opcodes reachable.
  task automatic test_random(int count);
    logic [4:0] op;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: op = OP_PUSH;
        2: op = OP_LDI;
        3: op = 5'($urandom_range(OP_ADD, OP_GTE));
        default: op = 5'($urandom_range(0, 31));
      endcase
      send_item(op, rand_word(), ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom));
    end
  endtask

  // Long receiver hold while the sender keeps offering items.
  task automatic test_backpressure();
    fork
      begin
        @(posedge clk);
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < 20; i++) send_item(OP_INC, 0, 0);
    join
  endtask

  initial begin
    m_acc = 0; m_pc = 0; m_depth = 0; m_cdepth = 0; m_len = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_length(16'hffff);
    test_overflow();
    test_random(60);
    set_length(16'd20);
    test_backpressure();
    test_random(60);
    set_length(16'd0);
    test_random(40);
    idle_on = 1'b0;
    set_length(16'd300);
    test_random(40);
    stop_sending();
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("stack_accumulator_cpu_execute_test OK");
    end else begin
      $display("stack_accumulator_cpu_execute_test NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
